// File: sv/ordered_list_insert_delete_top_assert.svh
// assertion macros for the ordered list block
// used by ordered_list_insert_delete_top; no other dependencies
`ifndef ORDERED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define OLID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define OLID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/olid_pkg.sv
// shared types and constants of the ordered list block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package olid_pkg;

  localparam int unsigned OLID_CAPACITY = 16;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned POS_W         = 5;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_DEL
  } cell_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_COMMIT
  } olid_state_e;

endpackage

`default_nettype wire

// File: sv/ordered_list_insert_delete_top.sv
// top level of the ordered list: control, sweep and output register
// depends on olid_pkg, olid_cell and ordered_list_insert_delete_top_assert.svh
//
//  channel | dir | tdata (low bit up)                               | tuser
//  s_axis  | in  | position[4:0], new_value[36:5], zero pad to 40   | opcode[2:0]
//  m_axis  | out | ok[0], read_value[32:1], found_position[37:33], | none
//          |     | list_length[42:38], is_empty[43], zero pad to 48 |
//
// insert, clear and unused opcodes go from the input beat straight to commit
// get, delete and locate sweep first; the entries rotate once
// through the cell chain and are inspected at cell zero, one per cycle
// one item at a time; a new input beat is taken in the cycle after the result
// is loaded, even while that result still waits in the output register
// reset clears the length and the control state; entries are not cleared
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete_top
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = OLID_CAPACITY
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // position, new_value
  input  wire logic [2:0]  s_axis_tuser,   // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // ok, read_value, found_position,
                                           // list_length, is_empty
);

`include "ordered_list_insert_delete_top_assert.svh"

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CntW-1:0] CapCnt  = CntW'(CAPACITY);

  olid_state_e state_q, state_d;

  logic [2:0]              op_q, op_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [IdxW-1:0]         step_q, step_d;
  logic                    found_q, found_d;
  logic [CntW-1:0]         fpos_q, fpos_d;
  logic signed [VAL_W-1:0] rd_q, rd_d;

  logic                    m_valid_q, m_valid_d;
  logic [47:0]             m_data_q, m_data_d;

  cell_cmd_e               cell_cmd;
  logic [IdxW-1:0]         cell_sel;
  logic signed [VAL_W-1:0] cell_data [CAPACITY];

  logic            in_beat;
  logic            out_free;
  logic            commit;
  logic [CmpW-1:0] pos_ext, cnt_ext, step_ext, pos_m1;
  logic            pos_ok_rd, pos_ok_ins;
  logic            res_ok;
  logic [VAL_W-1:0] res_rd;
  logic [CmpW-1:0] res_found_ext, res_len_ext;

  // ---------------- cell chain ----------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = val_q;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = cell_data[0];
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    olid_cell #(
      .IdxW  (IdxW),
      .Index (g)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cell_cmd),
      .sel_i       (cell_sel),
      .new_value_i (val_q),
      .lower_i     (lower),
      .upper_i     (upper),
      .data_o      (cell_data[g])
    );
  end

  // ---------------- decode ----------------
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign pos_ext  = CmpW'(pos_q);
  assign cnt_ext  = CmpW'(count_q);
  assign step_ext = CmpW'(step_q);
  assign pos_m1   = pos_ext - CmpW'(1);
  assign cell_sel = pos_m1[IdxW-1:0];

  assign pos_ok_rd  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_ok_ins = (count_q < CapCnt) && (pos_ext != '0) &&
                      ({1'b0, pos_ext} <= ({1'b0, cnt_ext} + (CmpW + 1)'(1)));

  // ---------------- control ----------------
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    count_d   = count_q;
    step_d    = step_q;
    found_d   = found_q;
    fpos_d    = fpos_q;
    rd_d      = rd_q;
    cell_cmd  = CELL_HOLD;
    commit    = 1'b0;
    res_ok    = 1'b0;
    res_rd    = '0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = s_axis_tuser;
          pos_d   = s_axis_tdata[POS_W-1:0];
          val_d   = s_axis_tdata[POS_W+VAL_W-1:POS_W];
          step_d  = '0;
          found_d = 1'b0;
          fpos_d  = '0;
          rd_d    = '0;
          case (op_e'(s_axis_tuser)) inside
            OP_DELETE, OP_GET, OP_LOCATE: state_d = ST_SWEEP;
            default:                      state_d = ST_COMMIT;
          endcase
        end
      end
      ST_SWEEP: begin
        // cell zero holds entry step_q during this cycle
        cell_cmd = CELL_ROT;
        if (!found_q && (step_ext < cnt_ext) && (cell_data[0] == val_q)) begin
          found_d = 1'b1;
          fpos_d  = CntW'(step_q) + CntW'(1);
        end
        if (step_ext == pos_m1) begin
          rd_d = cell_data[0];
        end
        step_d = step_q + IdxW'(1);
        if (step_q == LastIdx) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
          case (op_e'(op_q))
            OP_INSERT: begin
              if (pos_ok_ins) begin
                res_ok   = 1'b1;
                cell_cmd = CELL_INS;
                count_d  = count_q + CntW'(1);
              end
            end
            OP_DELETE: begin
              if (pos_ok_rd) begin
                res_ok   = 1'b1;
                res_rd   = rd_q;
                cell_cmd = CELL_DEL;
                count_d  = count_q - CntW'(1);
              end
            end
            OP_GET: begin
              if (pos_ok_rd) begin
                res_ok = 1'b1;
                res_rd = rd_q;
              end
            end
            OP_LOCATE: res_ok = found_q;
            OP_CLEAR: begin
              res_ok  = 1'b1;
              count_d = '0;
            end
            default: res_ok = 1'b0;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_found_ext = (op_e'(op_q) == OP_LOCATE) ? CmpW'(fpos_q) : '0;
  assign res_len_ext   = CmpW'(count_d);

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (commit) begin
      m_valid_d = 1'b1;
      m_data_d  = {4'b0, (count_d == '0), res_len_ext[POS_W-1:0],
                   res_found_ext[POS_W-1:0], res_rd, res_ok};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      step_q    <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      step_q    <= step_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    fpos_q   <= fpos_d;
    rd_q     <= rd_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------- assertions ----------------
  `OLID_ASSERT_NOW(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CapCnt,
    "list length above capacity")
  `OLID_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_beat, !s_axis_tready,
    "input taken while an item is in flight")
  `OLID_ASSERT_NEXT(a_commit_out, clk_i, rst_ni, commit, m_axis_tvalid,
    "result lost at commit")
  `OLID_ASSERT_NOW(a_empty_flag, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tdata[43] == (m_axis_tdata[42:38] == 5'd0) || (CAPACITY > 31),
    "empty flag disagrees with length")

endmodule

`default_nettype wire

// File: sv/olid_cell.sv
// one storage cell of the list chain: holds one entry
// depends on olid_pkg; neighbors wired by the top level
`timescale 1ns / 1ps
`default_nettype none

module olid_cell
  import olid_pkg::*;
#(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned Index = 0
) (
  input  wire logic                    clk_i,
  input  wire cell_cmd_e               cmd_i,
  input  wire logic [IdxW-1:0]         sel_i,
  input  wire logic signed [VAL_W-1:0] new_value_i,
  input  wire logic signed [VAL_W-1:0] lower_i,
  input  wire logic signed [VAL_W-1:0] upper_i,
  output logic signed [VAL_W-1:0]      data_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic signed [VAL_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i)
      CELL_HOLD: data_d = data_q;
      // rotate toward cell zero
      CELL_ROT:  data_d = upper_i;
      CELL_INS: begin
        if (MyIdx == sel_i) begin
          data_d = new_value_i;
        end else if (MyIdx > sel_i) begin
          data_d = lower_i;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= sel_i) begin
          data_d = upper_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire
